@@ rtl/lonely_edge_finder_core_assert.svh @@
// assertion macros shared by the lonely edge finder rtl
`ifndef LONELY_EDGE_FINDER_CORE_ASSERT_SVH
`define LONELY_EDGE_FINDER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LEF_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lonely edge finder assertion failed");

// next-cycle implication, checked out of reset
`define LEF_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lonely edge finder assertion failed");

`endif

@@ rtl/lef_pkg.sv @@
// shared types and helpers of the lonely edge finder
package lef_pkg;

  localparam int VW = 6;
  localparam int STACK_DEPTH = 32;
  localparam int SW = 5;

  typedef enum logic [3:0] {
    S_IDLE, S_NREAD, S_NROW, S_NWALK, S_SINIT, S_CAND,
    S_STEP, S_EDGE, S_POP, S_COUNT, S_DONE
  } state_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  typedef struct packed {
    logic        load;
    logic        run;
    logic [5:0]  row_index;
    logic [63:0] row_bits;
  } cmd_t;

  typedef struct packed {
    logic [63:0] lonely_mask;
    logic [6:0]  lonely_count;
    logic        status;
  } res_t;

  // index of the lowest set bit, 63 for an empty word
  function automatic logic [5:0] lowest_bit(input logic [63:0] x);
    logic [5:0] k;
    k = 6'd63;
    for (int b = 63; b >= 0; b--) begin
      if (x[b]) k = 6'(b);
    end
    return k;
  endfunction

endpackage

@@ rtl/lef_if.sv @@
// stream channel interfaces of the lonely edge finder
interface lef_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  row_index;
  logic [63:0] row_bits;
  modport source (output valid, func, row_index, row_bits, input ready);
  modport sink (input valid, func, row_index, row_bits, output ready);
endinterface

interface lef_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] lonely_mask;
  logic [6:0]  lonely_count;
  logic        status;
  modport source (output valid, lonely_mask, lonely_count, status, input ready);
  modport sink (input valid, lonely_mask, lonely_count, status, output ready);
endinterface

@@ rtl/lonely_edge_finder_core.sv @@
// top level of the lonely edge finder: channels, register port, result register
//
// in_ch carries beats with func, row_index and row_bits. a load beat (func 0)
// writes one adjacency row at its accepting edge; loads may come every cycle
// while idle and no result waits. a run beat (func 1) numbers the edges,
// walks every perfect matching and returns one beat on out_ch with lonely_mask,
// lonely_count and status. numbering reads each vertex row, latches it,
// walks it edge by edge and moves on; too many edges ends it at once.
// the search sets up, then per tried edge picks it and looks up its number,
// per level entered fetches the candidates, per backtrack checks and pops
// the stack, and finishes; it then counts the lonely edges one by one and
// ends in a done state. the registered ram read ports set this sequence.
// the result is valid the cycle after the done cycle; one run is in flight at
// a time. vertex_count is written over the cfg_ apb port at byte address 0;
// the user must write it only while idle, the block does not enforce this.
// reset returns the sequencer to idle and clears vertex_count; the adjacency
// and edge tables hold garbage until loaded.
// the result waits in an output register; while it is not taken no new
// beat is accepted, and a stalled result holds its value.
module lonely_edge_finder_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  lef_in_if.sink       in_ch,
  lef_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import lef_pkg::*;
  `include "lonely_edge_finder_core_assert.svh"

  logic [6:0] vcount_r;
  logic       out_valid_r;
  res_t       out_res_r;
  cmd_t       cmd;
  logic       eng_idle, eng_done, in_acc;
  res_t       eng_res;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {25'd0, vcount_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      vcount_r <= cfg_pwdata[6:0];
    end
  end

  // input beat decode
  assign in_ch.ready = eng_idle && !out_valid_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cmd = '{load: in_acc && in_ch.func == FUNC_LOAD,
                 run: in_acc && in_ch.func == FUNC_RUN,
                 row_index: in_ch.row_index, row_bits: in_ch.row_bits};

  lef_search #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_search (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .vertex_count(vcount_r),
    .idle(eng_idle), .done(eng_done), .res(eng_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (eng_done) out_res_r <= eng_res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.lonely_mask = out_res_r.lonely_mask;
  assign out_ch.lonely_count = out_res_r.lonely_count;
  assign out_ch.status = out_res_r.status;

  `LEF_ASSERT_IMP(a_err_zero, out_valid_r && out_res_r.status,
                  out_res_r.lonely_mask == 64'd0 && out_res_r.lonely_count == 7'd0)
  `LEF_ASSERT_NXT(a_done_valid, eng_done, out_valid_r)
  `LEF_ASSERT_NXT(a_run_busy, cmd.run, !in_ch.ready)
endmodule

@@ rtl/lef_ram.sv @@
// generic ram, one write port, one registered read port
module lef_ram #(
  parameter int W = 64,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/lef_search.sv @@
// edge numbering and depth-first matching search over ram-held state
module lef_search #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lef_pkg::cmd_t cmd,
  input  logic [6:0]    vertex_count,
  output logic          idle,
  output logic          done,
  output lef_pkg::res_t res
);
  import lef_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int EAW = AW + VW;
  localparam int STW = 192;

  state_t state_r, state_nxt;
  logic [6:0]  i_r, i_nxt, edges_r, edges_nxt, cnt_r, cnt_nxt;
  logic [63:0] nb_r, nb_nxt, rem_r, rem_nxt, cand_r, cand_nxt, mat_r, mat_nxt;
  logic [63:0] once_r, once_nxt, twice_r, twice_nxt;
  logic [63:0] mask_r, mask_nxt, scan_r, scan_nxt;
  logic [SW-1:0] d_r, d_nxt;
  logic [5:0] u_r, u_nxt, v_r, v_nxt;
  logic status_r, status_nxt;

  logic adj_we;
  logic [AW-1:0] adj_waddr, adj_raddr;
  logic [63:0] adj_rdata;
  logic et_we;
  logic [EAW-1:0] et_waddr, et_raddr;
  logic [5:0] et_wdata, et_rdata;
  logic st_we;
  logic [SW-1:0] st_waddr, st_raddr;
  logic [STW-1:0] st_rdata;

  logic [6:0] n;
  logic [63:0] vmask, above, nrem, nmat, lonely;
  logic [5:0] jb, vlow, nlow;

  // saturated vertex count and its vertex mask
  assign n = (vertex_count > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vertex_count;
  assign vmask = (n >= 7'd64) ? '1 : ((64'd1 << n[5:0]) - 64'd1);
  assign above = ~((64'd2 << i_r[5:0]) - 64'd1);
  assign jb = lowest_bit(nb_r);
  assign nrem = rem_r & ~((64'd1 << v_r) | (64'd1 << u_r));
  assign nmat = mat_r | (64'd1 << et_rdata);
  assign lonely = once_r & ~twice_r;
  assign vlow = lowest_bit(vmask);
  assign nlow = lowest_bit(nrem);

  lef_ram #(.W(64), .D(MAX_VERTICES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(cmd.row_bits),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );
  lef_ram #(.W(6), .D(MAX_VERTICES * 64)) u_etab (
    .clk(clk), .we(et_we), .waddr(et_waddr), .wdata(et_wdata),
    .raddr(et_raddr), .rdata(et_rdata)
  );
  lef_ram #(.W(STW), .D(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata({rem_r, cand_r, mat_r}),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd.run) state_nxt = (n == 7'd0) ? S_SINIT : S_NREAD;
      S_NREAD: state_nxt = S_NROW;
      S_NROW:  state_nxt = S_NWALK;
      S_NWALK: begin
        if (nb_r == 64'd0) state_nxt = (i_r + 7'd1 >= n) ? S_SINIT : S_NREAD;
        else if (edges_r >= 7'(MAX_EDGES)) state_nxt = S_DONE;
      end
      S_SINIT: state_nxt = (vmask == 64'd0) ? S_COUNT : S_CAND;
      S_CAND:  state_nxt = S_STEP;
      S_STEP: begin
        if (cand_r != 64'd0) state_nxt = S_EDGE;
        else state_nxt = (d_r == '0) ? S_COUNT : S_POP;
      end
      S_EDGE:  state_nxt = (nrem != 64'd0 && d_r != SW'(STACK_DEPTH - 1)) ? S_CAND : S_STEP;
      S_POP:   state_nxt = S_STEP;
      S_COUNT: if (scan_r == 64'd0) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    i_nxt = i_r; edges_nxt = edges_r; cnt_nxt = cnt_r; nb_nxt = nb_r;
    rem_nxt = rem_r; cand_nxt = cand_r; mat_nxt = mat_r;
    once_nxt = once_r; twice_nxt = twice_r; mask_nxt = mask_r; scan_nxt = scan_r;
    d_nxt = d_r; u_nxt = u_r; v_nxt = v_r; status_nxt = status_r;
    adj_we = 1'b0; adj_waddr = cmd.row_index[AW-1:0]; adj_raddr = i_r[AW-1:0];
    et_we = 1'b0; et_waddr = {i_r[AW-1:0], jb}; et_wdata = edges_r[5:0];
    et_raddr = {v_r[AW-1:0], u_r};
    st_we = 1'b0; st_waddr = d_r; st_raddr = d_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load && 7'(cmd.row_index) < 7'(MAX_VERTICES)) adj_we = 1'b1;
        if (cmd.run) begin
          i_nxt = 7'd0; edges_nxt = 7'd0; status_nxt = 1'b0;
        end
      end
      S_NROW: nb_nxt = adj_rdata & vmask & above;
      S_NWALK: begin
        if (nb_r == 64'd0) begin
          i_nxt = i_r + 7'd1;
          adj_raddr = i_nxt[AW-1:0];
        end else if (edges_r >= 7'(MAX_EDGES)) begin
          status_nxt = 1'b1; mask_nxt = 64'd0; cnt_nxt = 7'd0;
        end else begin
          et_we = 1'b1;
          edges_nxt = edges_r + 7'd1;
          nb_nxt = nb_r & (nb_r - 64'd1);
        end
      end
      S_SINIT: begin
        once_nxt = 64'd0; twice_nxt = 64'd0;
        rem_nxt = vmask; mat_nxt = 64'd0; d_nxt = '0;
        mask_nxt = 64'd0; scan_nxt = 64'd0; cnt_nxt = 7'd0;
        adj_raddr = vlow[AW-1:0];
      end
      S_CAND: cand_nxt = adj_rdata & rem_r & ~(64'd1 << lowest_bit(rem_r));
      S_STEP: begin
        if (cand_r != 64'd0) begin
          u_nxt = lowest_bit(cand_r);
          v_nxt = lowest_bit(rem_r);
          et_raddr = {v_nxt[AW-1:0], u_nxt};
          cand_nxt = cand_r & (cand_r - 64'd1);
        end else if (d_r == '0) begin
          mask_nxt = lonely; scan_nxt = lonely; cnt_nxt = 7'd0;
        end else begin
          d_nxt = d_r - SW'(1);
          st_raddr = d_nxt;
        end
      end
      S_EDGE: begin
        if (nrem == 64'd0) begin
          twice_nxt = twice_r | (once_r & nmat);
          once_nxt = once_r | nmat;
        end else if (d_r != SW'(STACK_DEPTH - 1)) begin
          st_we = 1'b1;
          rem_nxt = nrem; mat_nxt = nmat; d_nxt = d_r + SW'(1);
          adj_raddr = nlow[AW-1:0];
        end
      end
      S_POP: {rem_nxt, cand_nxt, mat_nxt} = st_rdata;
      S_COUNT: begin
        if (scan_r != 64'd0) begin
          scan_nxt = scan_r & (scan_r - 64'd1);
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      default: ;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r <= i_nxt; edges_r <= edges_nxt; cnt_r <= cnt_nxt; nb_r <= nb_nxt;
    rem_r <= rem_nxt; cand_r <= cand_nxt; mat_r <= mat_nxt;
    once_r <= once_nxt; twice_r <= twice_nxt; mask_r <= mask_nxt; scan_r <= scan_nxt;
    d_r <= d_nxt; u_r <= u_nxt; v_r <= v_nxt; status_r <= status_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign res = '{lonely_mask: mask_r, lonely_count: cnt_r, status: status_r};
endmodule

@@ dv/lef_checker.sv @@
// checker for the lonely edge finder: mirrors the graph, predicts each run result, compares
`timescale 1ns / 1ps

module lef_checker (
  input  logic        clk,
  input  logic        rst_n,
  lef_in_if           in_ch,
  lef_out_if          out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          outstanding,
  output int          runs_checked,
  output int          overflow_runs
);
  import lef_pkg::*;

  localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;
  localparam int EDGE_LIMIT = 64;
  localparam int SEARCH_DEPTH = 32;

  // mirrored graph and register
  logic [63:0] adj_rows [64];
  logic [5:0]  edge_ids [64][64];
  logic [6:0]  vcount;
  res_t        lonely_q[$];

  function automatic int low_idx(input logic [63:0] x);
    for (int b = 0; b < 64; b++) begin
      if (x[b]) return b;
    end
    return 63;
  endfunction

  // remaining neighbours above the lowest remaining vertex
  function automatic logic [63:0] open_partners(input logic [63:0] rem);
    logic [63:0] c;
    int v;
    v = low_idx(rem);
    c = adj_rows[v] & rem;
    c[v] = 1'b0;
    return c;
  endfunction

  // number the edges, walk every perfect matching, keep edges hit exactly once
  function automatic res_t predict_lonely();
    res_t r;
    int n, edges, d, v, u;
    logic [63:0] vmask, rem, nrem, nmat, hit1, hit2, lonely;
    logic [63:0] rem_st [SEARCH_DEPTH];
    logic [63:0] cand_st [SEARCH_DEPTH];
    logic [63:0] mat_st [SEARCH_DEPTH];
    r = '0;
    n = (vcount > 7'd64) ? 64 : int'(vcount);
    vmask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    edges = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (adj_rows[i][j]) begin
          if (edges >= EDGE_LIMIT) begin
            r.status = 1'b1;
            return r;
          end
          edge_ids[i][j] = 6'(edges);
          edges++;
        end
      end
    end
    hit1 = '0;
    hit2 = '0;
    if (n > 0) begin
      d = 0;
      rem_st[0] = vmask;
      mat_st[0] = '0;
      cand_st[0] = open_partners(vmask);
      forever begin
        if (cand_st[d] == '0) begin
          if (d == 0) break;
          d--;
          continue;
        end
        u = low_idx(cand_st[d]);
        cand_st[d][u] = 1'b0;
        rem = rem_st[d];
        v = low_idx(rem);
        nrem = rem;
        nrem[v] = 1'b0;
        nrem[u] = 1'b0;
        nmat = mat_st[d];
        nmat[edge_ids[v][u]] = 1'b1;
        if (nrem == '0) begin
          hit2 |= hit1 & nmat;
          hit1 |= nmat;
        end else if (d + 1 < SEARCH_DEPTH) begin
          d++;
          rem_st[d] = nrem;
          mat_st[d] = nmat;
          cand_st[d] = open_partners(nrem);
        end
      end
    end
    lonely = hit1 & ~hit2;
    r.lonely_mask = lonely;
    r.lonely_count = 7'($countones(lonely));
    return r;
  endfunction

  // watch register writes, input beats and result beats
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      vcount <= '0;
      outstanding <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == REG_VERTEX_COUNT)
        vcount <= cfg_pwdata[6:0];
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_LOAD) adj_rows[in_ch.row_index] = in_ch.row_bits;
        else lonely_q.push_back(predict_lonely());
      end
      if (out_ch.valid && out_ch.ready) begin
        if (lonely_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat mask=%h", out_ch.lonely_mask);
        end else begin
          want = lonely_q.pop_front();
          runs_checked++;
          if (want.status) overflow_runs++;
          if (out_ch.lonely_mask !== want.lonely_mask || out_ch.lonely_count !== want.lonely_count
              || out_ch.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp mask=%h cnt=%0d st=%0d  got mask=%h cnt=%0d st=%0d",
                       want.lonely_mask, want.lonely_count, want.status,
                       out_ch.lonely_mask, out_ch.lonely_count, out_ch.status);
          end
        end
      end
      outstanding <= lonely_q.size();
    end
  end

  initial begin
    fail_count = 0;
    runs_checked = 0;
    overflow_runs = 0;
    for (int i = 0; i < 64; i++) adj_rows[i] = '0;
  end

endmodule

@@ dv/tb_top.sv @@
// top of the lonely edge finder testbench: clock, reset, stimulus, verdict
`timescale 1ns / 1ps

module tb_top;
  import lef_pkg::*;

  localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int fail_count, outstanding, runs_checked, overflow_runs;
  int beats_sent, burst_left, cycles;

  lef_in_if in_ch ();
  lef_out_if out_ch ();

  lonely_edge_finder_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  lef_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .outstanding(outstanding),
    .runs_checked(runs_checked), .overflow_runs(overflow_runs)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lonely_edge_finder_core regression: fail");
      $finish;
    end
  end

  // receiver: random ready pattern, one long hold-off once results are flowing
  initial begin
    int taken, left;
    bit rdy, held;
    taken = 0;
    left = 0;
    rdy = 1'b0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (left == 0) begin
        if (!held && taken >= 40) begin
          held = 1'b1;
          rdy = 1'b0;
          left = 3000;
        end else begin
          rdy = ($urandom_range(0, 3) != 0);
          left = rdy ? $urandom_range(1, 30) : $urandom_range(1, 12);
        end
      end else begin
        left--;
      end
      out_ch.ready <= rdy;
    end
  end

  // one input beat, then a burst continuation or a random gap
  task automatic send_beat(input logic f, input logic [5:0] r, input logic [63:0] b);
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.row_index <= r;
    in_ch.row_bits <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_run();
    send_beat(FUNC_RUN, 6'($urandom), {$urandom, $urandom});
  endtask

  // wait for every result, let a trailing load settle, then write the register
  task automatic set_vertex_count(input logic [6:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_VERTEX_COUNT;
    cfg_pwdata <= 32'({$urandom, 7'b0}) | 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] random_row(input bit sparse);
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    if (sparse) return a & b & {$urandom, $urandom};
    case ($urandom_range(0, 2))
      0: return a & b;
      1: return a;
      default: return a | b;
    endcase
  endfunction

  initial begin
    int n, sel;
    logic [63:0] row;
    rst_n = 1'b0;
    cycles = 0;
    beats_sent = 0;
    burst_left = 0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_LOAD;
    in_ch.row_index <= '0;
    in_ch.row_bits <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty graph: one empty matching
    set_vertex_count(7'd0);
    send_run();
    // square with self loop, stray high bit and a junk lower triangle: two matchings
    set_vertex_count(7'd4);
    send_beat(FUNC_LOAD, 6'd0, 64'h8000_0000_0000_000B);
    send_beat(FUNC_LOAD, 6'd1, 64'h0000_0000_0000_0004);
    send_beat(FUNC_LOAD, 6'd2, 64'h0000_0000_0000_0008);
    send_beat(FUNC_LOAD, 6'd3, '1);
    send_run();
    // path: a single matching, every matched edge lonely
    send_beat(FUNC_LOAD, 6'd0, 64'h0000_0000_0000_0002);
    send_run();
    // odd vertex count: no matching
    set_vertex_count(7'd3);
    send_run();
    // complete graph on twelve vertices overflows the edge limit
    set_vertex_count(7'd12);
    for (int i = 0; i < 12; i++) send_beat(FUNC_LOAD, 6'(i), '1);
    send_run();

    // full width by saturation: 17-rung ladder and forced pairs, exactly the edge limit of 64
    set_vertex_count(7'd127);
    for (int i = 0; i < 64; i++) begin
      row = (64'd1 << (i ^ 1)) | (64'd1 << i) | (((64'd1 << i) - 64'd1) & {$urandom, $urandom});
      if (i < 32) row |= 64'd1 << (i + 2);
      send_beat(FUNC_LOAD, 6'(i), row);
    end
    send_run();
    // one more edge tips it over the limit
    set_vertex_count(7'd64);
    send_beat(FUNC_LOAD, 6'd32, (64'd1 << 33) | (64'd1 << 34));
    send_run();

    // random phases: new count, a full graph load, then mixed runs and row updates
    while (beats_sent < 650) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) n = $urandom_range(2, 8);
      else if (sel < 8) n = $urandom_range(9, 10);
      else n = $urandom_range(0, 3);
      set_vertex_count(7'(n));
      for (int i = 0; i < n; i++) send_beat(FUNC_LOAD, 6'(i), random_row(n > 8));
      repeat ($urandom_range(3, 10)) begin
        if ($urandom_range(0, 9) < 5) send_run();
        else send_beat(FUNC_LOAD, 6'($urandom_range(0, 63)), random_row(n > 8));
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (50) @(posedge clk);
    $display("covered %0d input beats and %0d searches, %0d of them over the edge limit",
             beats_sent, runs_checked, overflow_runs);
    $display("vertex counts from 0 to 127 incl. saturation, odd and empty graphs, long output stall");
    if (fail_count == 0) begin
      $display("lonely_edge_finder_core regression: pass");
    end else begin
      $display("lonely_edge_finder_core regression: fail");
    end
    $finish;
  end

endmodule
